[src/pbrf_pkg.sv]
// ----------------------------------------------------------------------------
// Polynomial bisection root finder package
// Shared widths, register indexes, status codes and sequencer types.
// ----------------------------------------------------------------------------
`default_nettype none

package pbrf_pkg;

  localparam int WORD_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_TERMS   = 6;
  localparam int TERM_W      = 3;
  localparam int TOL_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 6;
  localparam int HALVING_CAP = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int PROD_W      = 2 * WORD_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TERM_COUNT = 3'd0,
    REG_TOLERANCE  = 3'd1,
    REG_COEF_0     = 3'd2,
    REG_COEF_1     = 3'd3,
    REG_COEF_2     = 3'd4,
    REG_COEF_3     = 3'd5,
    REG_COEF_4     = 3'd6,
    REG_COEF_5     = 3'd7
  } cfg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSIDE    = 2'd0,
    ST_LOWER     = 2'd1,
    ST_UPPER     = 2'd2,
    ST_NO_CHANGE = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_ADD   = 8'b0000_1000,
    S_DONE  = 8'b0001_0000,
    S_JUDGE = 8'b0010_0000,
    S_STEP  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  // Which point the Horner unit is currently evaluating.
  typedef enum logic [2:0] {
    PH_LOW  = 3'b001,
    PH_HIGH = 3'b010,
    PH_MID  = 3'b100
  } phase_t;

endpackage

`default_nettype wire

[src/pbrf_in_if.sv]
// ----------------------------------------------------------------------------
// Query channel
// Valid/ready channel carrying the two search bounds of one item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbrf_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pbrf_pkg::WORD_W-1:0] lower_bound;
  logic signed [pbrf_pkg::WORD_W-1:0] upper_bound;

  modport source (output valid, output lower_bound, output upper_bound, input ready);
  modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

`default_nettype wire

[src/pbrf_out_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the root, its value, status and halving count.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbrf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pbrf_pkg::WORD_W-1:0]   root_estimate;
  logic signed [pbrf_pkg::WORD_W-1:0]   value_at_root;
  logic        [pbrf_pkg::STATUS_W-1:0] status;
  logic        [pbrf_pkg::COUNT_W-1:0]  iteration_count;

  modport source (output valid, output root_estimate, output value_at_root,
                  output status, output iteration_count, input ready);
  modport sink   (input valid, input root_estimate, input value_at_root,
                  input status, input iteration_count, output ready);
endinterface

`default_nettype wire

[src/pbrf_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbrf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pbrf_pkg::CFG_INDEX_W-1:0]    index;
  logic [pbrf_pkg::WORD_W-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/poly_bisection_root_finder_core.sv]
// ----------------------------------------------------------------------------
// Polynomial bisection root finder core
// Finds a root of a fixed-point polynomial between two bounds by bisection,
// with one shared multiplier stepping through Horner's rule.
// ----------------------------------------------------------------------------
// Usage: program term_count, tolerance and coef_0..coef_5 over cfg_if while
// the block is idle (cfg_if.ready is always high). Each item on in_if brings
// two Q16.16 bounds in either order; one item leaves on out_if per query.
// A polynomial evaluation of the n terms in use loads the top coefficient,
// then passes every further Horner term through the 32x32 multiplier and the
// shift/add/saturate step in turn. A query has an accept step, two end
// evaluations, then for each halving one midpoint evaluation plus judge and
// step bookkeeping, and a final load of the output register.
// Bounds already narrower than the tolerance need no halving after the
// first midpoint evaluation.
// The block takes one item at a time: in_if.ready is high only while idle.
// The result sits in an output register; while the receiver stalls, the
// finished result waits in a staging register and no new item is taken.
// Reset (rst_n low, synchronous) empties the block and sets term_count to
// one, tolerance to one and every coefficient to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_bisection_root_finder_core (
  input  wire          clk,
  input  wire          rst_n,
  pbrf_in_if.sink      in_if,
  pbrf_out_if.source   out_if,
  pbrf_cfg_if.sink     cfg_if
);

  localparam int W = pbrf_pkg::WORD_W;

  // Configuration registers.
  logic [pbrf_pkg::TERM_W-1:0] term_count_r, term_count_nxt;
  logic [pbrf_pkg::TOL_W-1:0]  tol_r, tol_nxt;
  logic signed [W-1:0]         coef_r   [pbrf_pkg::MAX_TERMS];
  logic signed [W-1:0]         coef_nxt [pbrf_pkg::MAX_TERMS];

  // Sequencer and datapath.
  pbrf_pkg::state_t             state_r, state_nxt;
  pbrf_pkg::phase_t             phase_r, phase_nxt;
  logic                         first_r, first_nxt;
  logic signed [W-1:0]          low_r, low_nxt;
  logic signed [W-1:0]          high_r, high_nxt;
  logic signed [W-1:0]          mid_r, mid_nxt;
  logic signed [W-1:0]          vlow_r, vlow_nxt;
  logic signed [W-1:0]          acc_r, acc_nxt;
  logic signed [W-1:0]          x_r, x_nxt;
  logic [pbrf_pkg::TERM_W-1:0]  idx_r, idx_nxt;
  logic signed [pbrf_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [pbrf_pkg::COUNT_W-1:0] count_r, count_nxt;

  // Staged result and output register.
  logic signed [W-1:0]            res_root_r, res_root_nxt;
  logic signed [W-1:0]            res_value_r, res_value_nxt;
  pbrf_pkg::status_t              res_status_r, res_status_nxt;
  logic [pbrf_pkg::COUNT_W-1:0]   res_count_r, res_count_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [W-1:0]            out_root_r, out_root_nxt;
  logic signed [W-1:0]            out_value_r, out_value_nxt;
  logic [pbrf_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [pbrf_pkg::COUNT_W-1:0]   out_count_r, out_count_nxt;

  // Derived combinational values.
  logic [pbrf_pkg::TERM_W-1:0] top_term;
  logic [W-1:0]                tol_eff;
  logic [W-1:0]                width;
  logic [W-1:0]                half_mid;
  logic signed [W-1:0]         horner_sum;
  logic [W-1:0]                cfg_coef_pos;

  function automatic logic is_pos(input logic signed [W-1:0] v);
    is_pos = !v[W-1] && (v != '0);
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic same_sign(input logic signed [W-1:0] a,
                                     input logic signed [W-1:0] b);
    same_sign = (is_pos(a) && is_pos(b)) || (a[W-1] && b[W-1]);
  endfunction

  function automatic logic opp_sign(input logic signed [W-1:0] a,
                                    input logic signed [W-1:0] b);
    opp_sign = (is_pos(a) && b[W-1]) || (a[W-1] && is_pos(b));
  endfunction

  // Floor-shifted product plus coefficient, saturated to the word.
  function automatic logic signed [W-1:0] horner_add(
      input logic signed [pbrf_pkg::PROD_W-1:0] p,
      input logic signed [W-1:0]                c);
    logic signed [pbrf_pkg::PROD_W-pbrf_pkg::FRAC_BITS:0] s;
    s = {p[pbrf_pkg::PROD_W-1], p[pbrf_pkg::PROD_W-1:pbrf_pkg::FRAC_BITS]}
        + {{(pbrf_pkg::PROD_W-pbrf_pkg::FRAC_BITS-W+1){c[W-1]}}, c};
    if (s[pbrf_pkg::PROD_W-pbrf_pkg::FRAC_BITS:W-1] == '0 ||
        s[pbrf_pkg::PROD_W-pbrf_pkg::FRAC_BITS:W-1] == '1) begin
      horner_add = s[W-1:0];
    end else if (s[pbrf_pkg::PROD_W-pbrf_pkg::FRAC_BITS]) begin
      horner_add = {1'b1, {(W-1){1'b0}}};
    end else begin
      horner_add = {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  always_comb begin
    // A term count of zero acts as one and anything above six as six.
    if (term_count_r == '0) begin
      top_term = '0;
    end else if (term_count_r > pbrf_pkg::TERM_W'(pbrf_pkg::MAX_TERMS)) begin
      top_term = pbrf_pkg::TERM_W'(pbrf_pkg::MAX_TERMS - 1);
    end else begin
      top_term = term_count_r - 1'b1;
    end
    tol_eff    = (tol_r == '0) ? W'(1) : {{(W-pbrf_pkg::TOL_W){1'b0}}, tol_r};
    width      = high_r - low_r;
    half_mid   = low_r + {1'b0, width[W-1:1]};
    horner_sum = horner_add(prod_r, coef_r[idx_r]);
    cfg_coef_pos = {{(W-pbrf_pkg::CFG_INDEX_W){1'b0}}, cfg_if.index}
                   - W'(pbrf_pkg::REG_COEF_0);
  end

  assign in_if.ready            = (state_r == pbrf_pkg::S_IDLE);
  assign cfg_if.ready           = 1'b1;
  assign out_if.valid           = out_valid_r;
  assign out_if.root_estimate   = out_root_r;
  assign out_if.value_at_root   = out_value_r;
  assign out_if.status          = out_status_r;
  assign out_if.iteration_count = out_count_r;

  always_comb begin
    term_count_nxt = term_count_r;
    tol_nxt        = tol_r;
    coef_nxt       = coef_r;
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    first_nxt      = first_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    mid_nxt        = mid_r;
    vlow_nxt       = vlow_r;
    acc_nxt        = acc_r;
    x_nxt          = x_r;
    idx_nxt        = idx_r;
    prod_nxt       = prod_r;
    count_nxt      = count_r;
    res_root_nxt   = res_root_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r;
    out_root_nxt   = out_root_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    if (cfg_if.valid) begin
      case (pbrf_pkg::cfg_index_t'(cfg_if.index))
        pbrf_pkg::REG_TERM_COUNT: term_count_nxt = cfg_if.data[pbrf_pkg::TERM_W-1:0];
        pbrf_pkg::REG_TOLERANCE:  tol_nxt = cfg_if.data[pbrf_pkg::TOL_W-1:0];
        default: coef_nxt[cfg_coef_pos[pbrf_pkg::TERM_W-1:0]] = cfg_if.data;
      endcase
    end

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      pbrf_pkg::S_IDLE: begin
        if (in_if.valid) begin
          if (in_if.lower_bound < in_if.upper_bound) begin
            low_nxt  = in_if.lower_bound;
            high_nxt = in_if.upper_bound;
          end else begin
            low_nxt  = in_if.upper_bound;
            high_nxt = in_if.lower_bound;
          end
          x_nxt     = low_nxt;
          idx_nxt   = top_term;
          count_nxt = '0;
          phase_nxt = pbrf_pkg::PH_LOW;
          state_nxt = pbrf_pkg::S_LOAD;
        end
      end

      pbrf_pkg::S_LOAD: begin
        acc_nxt   = coef_r[idx_r];
        state_nxt = pbrf_pkg::S_MUL;
      end

      pbrf_pkg::S_MUL: begin
        if (idx_r == '0) begin
          state_nxt = pbrf_pkg::S_DONE;
        end else begin
          prod_nxt  = acc_r * x_r;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = pbrf_pkg::S_ADD;
        end
      end

      pbrf_pkg::S_ADD: begin
        acc_nxt   = horner_sum;
        state_nxt = pbrf_pkg::S_MUL;
      end

      pbrf_pkg::S_DONE: begin
        case (phase_r)
          pbrf_pkg::PH_LOW: begin
            vlow_nxt  = acc_r;
            x_nxt     = high_r;
            idx_nxt   = top_term;
            phase_nxt = pbrf_pkg::PH_HIGH;
            state_nxt = pbrf_pkg::S_LOAD;
          end
          pbrf_pkg::PH_HIGH: begin
            state_nxt     = pbrf_pkg::S_OUT;
            res_count_nxt = '0;
            if (same_sign(vlow_r, acc_r)) begin
              res_root_nxt   = '0;
              res_value_nxt  = '0;
              res_status_nxt = pbrf_pkg::ST_NO_CHANGE;
            end else if (mag(vlow_r) < tol_eff) begin
              res_root_nxt   = low_r;
              res_value_nxt  = vlow_r;
              res_status_nxt = pbrf_pkg::ST_LOWER;
            end else if (mag(acc_r) < tol_eff) begin
              res_root_nxt   = high_r;
              res_value_nxt  = acc_r;
              res_status_nxt = pbrf_pkg::ST_UPPER;
            end else begin
              mid_nxt   = half_mid;
              x_nxt     = half_mid;
              idx_nxt   = top_term;
              first_nxt = 1'b1;
              phase_nxt = pbrf_pkg::PH_MID;
              state_nxt = pbrf_pkg::S_LOAD;
            end
          end
          default: begin
            // The first midpoint value doubles as the first halving's value.
            if (first_r && !(width > tol_eff)) begin
              res_root_nxt   = mid_r;
              res_value_nxt  = acc_r;
              res_status_nxt = pbrf_pkg::ST_INSIDE;
              res_count_nxt  = count_r;
              state_nxt      = pbrf_pkg::S_OUT;
            end else begin
              if (first_r) begin
                count_nxt = count_r + 1'b1;
              end
              state_nxt = pbrf_pkg::S_JUDGE;
            end
          end
        endcase
      end

      pbrf_pkg::S_JUDGE: begin
        if (mag(acc_r) < tol_eff) begin
          res_root_nxt   = mid_r;
          res_value_nxt  = acc_r;
          res_status_nxt = pbrf_pkg::ST_INSIDE;
          res_count_nxt  = count_r;
          state_nxt      = pbrf_pkg::S_OUT;
        end else begin
          if (opp_sign(vlow_r, acc_r)) begin
            high_nxt = mid_r;
          end else begin
            low_nxt  = mid_r;
            vlow_nxt = acc_r;
          end
          state_nxt = pbrf_pkg::S_STEP;
        end
      end

      pbrf_pkg::S_STEP: begin
        if (width > tol_eff && count_r < pbrf_pkg::COUNT_W'(pbrf_pkg::HALVING_CAP)) begin
          mid_nxt   = half_mid;
          x_nxt     = half_mid;
          idx_nxt   = top_term;
          count_nxt = count_r + 1'b1;
          first_nxt = 1'b0;
          phase_nxt = pbrf_pkg::PH_MID;
          state_nxt = pbrf_pkg::S_LOAD;
        end else begin
          res_root_nxt   = mid_r;
          res_value_nxt  = acc_r;
          res_status_nxt = pbrf_pkg::ST_INSIDE;
          res_count_nxt  = count_r;
          state_nxt      = pbrf_pkg::S_OUT;
        end
      end

      pbrf_pkg::S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_root_nxt   = res_root_r;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = res_count_r;
          state_nxt      = pbrf_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pbrf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= pbrf_pkg::TERM_W'(1);
      tol_r        <= pbrf_pkg::TOL_W'(1);
      for (int i = 0; i < pbrf_pkg::MAX_TERMS; i++) begin
        coef_r[i] <= '0;
      end
      state_r      <= pbrf_pkg::S_IDLE;
      phase_r      <= pbrf_pkg::PH_LOW;
      out_valid_r  <= 1'b0;
    end else begin
      term_count_r <= term_count_nxt;
      tol_r        <= tol_nxt;
      coef_r       <= coef_nxt;
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r      <= first_nxt;
    low_r        <= low_nxt;
    high_r       <= high_nxt;
    mid_r        <= mid_nxt;
    vlow_r       <= vlow_nxt;
    acc_r        <= acc_nxt;
    x_r          <= x_nxt;
    idx_r        <= idx_nxt;
    prod_r       <= prod_nxt;
    count_r      <= count_nxt;
    res_root_r   <= res_root_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    out_root_r   <= out_root_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

`default_nettype wire

[tb/poly_bisection_root_finder_core_tb.sv]
// ----------------------------------------------------------------------------
// Polynomial bisection root finder core testbench
// Programs the coefficient and tolerance registers through a series of
// settings, sends bound pairs with random gaps and checks every returned
// root, value, status and halving count against a bit-true predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_bisection_root_finder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [pbrf_pkg::WORD_W-1:0] q16_t;

  typedef struct packed {
    q16_t                          root;
    q16_t                          value;
    pbrf_pkg::status_t             status;
    logic [pbrf_pkg::COUNT_W-1:0]  halvings;
  } root_report_t;

  localparam int     ONE            = 1 << pbrf_pkg::FRAC_BITS;
  localparam q16_t   Q_MAX          = 32'sh7FFF_FFFF;
  localparam q16_t   Q_MIN          = 32'sh8000_0000;
  localparam longint SAT_HI         = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO         = 64'shFFFF_FFFF_8000_0000;
  localparam int     RANDOM_PHASES  = 13;
  localparam int     PHASE_ITEMS    = 100;
  localparam int     SETTLE_CYCLES  = 600;
  localparam int     WATCHDOG_LIMIT = 5000;

  // Expected results of the bisection search, worked out from a private copy
  // of the register file.
  class root_scoreboard;
    logic [pbrf_pkg::TERM_W-1:0] term_count;
    logic [pbrf_pkg::TOL_W-1:0]  tolerance;
    q16_t                        coef [pbrf_pkg::MAX_TERMS];
    root_report_t                expected_reports [$];
    int                          fail_count;

    function new();
      term_count = pbrf_pkg::TERM_W'(1);
      tolerance  = pbrf_pkg::TOL_W'(1);
      foreach (coef[k]) coef[k] = '0;
      fail_count = 0;
    endfunction

    function void set_register(pbrf_pkg::cfg_index_t idx,
                               logic [pbrf_pkg::WORD_W-1:0] data);
      case (idx)
        pbrf_pkg::REG_TERM_COUNT: term_count = data[pbrf_pkg::TERM_W-1:0];
        pbrf_pkg::REG_TOLERANCE:  tolerance  = data[pbrf_pkg::TOL_W-1:0];
        default: coef[int'(idx) - int'(pbrf_pkg::REG_COEF_0)] = data;
      endcase
    endfunction

    function q16_t horner_eval(q16_t x);
      int     n;
      int     k;
      longint acc;
      longint sum;
      n = (term_count == 0) ? 1 :
          ((term_count > pbrf_pkg::MAX_TERMS) ? pbrf_pkg::MAX_TERMS : term_count);
      acc = longint'(coef[n-1]);
      for (k = n - 2; k >= 0; k--) begin
        sum = ((acc * longint'(x)) >>> pbrf_pkg::FRAC_BITS) + longint'(coef[k]);
        if (sum > SAT_HI) acc = SAT_HI;
        else if (sum < SAT_LO) acc = SAT_LO;
        else acc = sum;
      end
      return acc[pbrf_pkg::WORD_W-1:0];
    endfunction

    function int sign_of(q16_t v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
    endfunction

    function bit near_zero(q16_t v, logic [pbrf_pkg::WORD_W-1:0] tol);
      longint m;
      m = (v < 0) ? -longint'(v) : longint'(v);
      return m < longint'(tol);
    endfunction

    function root_report_t solve_query(q16_t a, q16_t b);
      root_report_t                r;
      q16_t                        lo;
      q16_t                        hi;
      q16_t                        mid;
      q16_t                        v_lo;
      q16_t                        v_hi;
      q16_t                        v_mid;
      logic [pbrf_pkg::WORD_W-1:0] tol;
      logic [pbrf_pkg::WORD_W-1:0] span;
      int                          halvings;
      tol  = (tolerance == 0) ? 1 : tolerance;
      lo   = (a < b) ? a : b;
      hi   = (a < b) ? b : a;
      v_lo = horner_eval(lo);
      v_hi = horner_eval(hi);
      if (sign_of(v_lo) * sign_of(v_hi) > 0) begin
        r = '{root: '0, value: '0, status: pbrf_pkg::ST_NO_CHANGE, halvings: '0};
        return r;
      end
      if (near_zero(v_lo, tol)) begin
        r = '{root: lo, value: v_lo, status: pbrf_pkg::ST_LOWER, halvings: '0};
        return r;
      end
      if (near_zero(v_hi, tol)) begin
        r = '{root: hi, value: v_hi, status: pbrf_pkg::ST_UPPER, halvings: '0};
        return r;
      end
      span     = hi - lo;
      mid      = lo + (span >> 1);
      v_mid    = horner_eval(mid);
      halvings = 0;
      while (span > tol && halvings < pbrf_pkg::HALVING_CAP) begin
        mid = lo + (span >> 1);
        halvings++;
        v_mid = horner_eval(mid);
        if (near_zero(v_mid, tol)) break;
        if (sign_of(v_lo) * sign_of(v_mid) < 0) begin
          hi = mid;
        end else begin
          lo   = mid;
          v_lo = v_mid;
        end
        span = hi - lo;
      end
      r = '{root: mid, value: v_mid, status: pbrf_pkg::ST_INSIDE,
            halvings: halvings[pbrf_pkg::COUNT_W-1:0]};
      return r;
    endfunction

    function void note_query(q16_t a, q16_t b);
      expected_reports.push_back(solve_query(a, b));
    endfunction

    function void check_result(root_report_t got);
      root_report_t want;
      bit           bad;
      if (expected_reports.size() == 0) begin
        $display("%0t: result with nothing expected: root %0d value %0d status %0d count %0d",
                 $time, got.root, got.value, got.status, got.halvings);
        fail_count++;
        return;
      end
      want = expected_reports.pop_front();
      bad  = 1'b0;
      if (got.root !== want.root) begin
        $display("%0t: root_estimate expected %0d got %0d", $time, want.root, got.root);
        bad = 1'b1;
      end
      if (got.value !== want.value) begin
        $display("%0t: value_at_root expected %0d got %0d", $time, want.value, got.value);
        bad = 1'b1;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        bad = 1'b1;
      end
      if (got.halvings !== want.halvings) begin
        $display("%0t: iteration_count expected %0d got %0d", $time, want.halvings,
                 got.halvings);
        bad = 1'b1;
      end
      if (bad) fail_count++;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   send_burst;
  bit   take_burst;

  root_scoreboard roots;

  pbrf_in_if  in_bus ();
  pbrf_out_if out_bus ();
  pbrf_cfg_if cfg_bus ();

  poly_bisection_root_finder_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 8);
  endfunction

  // Valid stays high after the handshake so that a zero gap gives
  // back-to-back items without a low pulse.
  task automatic send_query(q16_t a, q16_t b);
    int gap;
    gap = draw_gap(send_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.lower_bound <= a;
    in_bus.upper_bound <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    roots.note_query(a, b);
  endtask

  task automatic write_register(pbrf_pkg::cfg_index_t idx,
                                logic [pbrf_pkg::WORD_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    roots.set_register(idx, data);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (roots.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setup(logic [pbrf_pkg::WORD_W-1:0] terms,
                             logic [pbrf_pkg::WORD_W-1:0] tol_data,
                             q16_t c [pbrf_pkg::MAX_TERMS]);
    int k;
    wait_drained();
    write_register(pbrf_pkg::REG_TERM_COUNT, terms);
    write_register(pbrf_pkg::REG_TOLERANCE, tol_data);
    for (k = 0; k < pbrf_pkg::MAX_TERMS; k++) begin
      write_register(pbrf_pkg::cfg_index_t'(int'(pbrf_pkg::REG_COEF_0) + k), c[k]);
    end
  endtask

  function automatic q16_t random_coef(int style);
    case (style)
      0:       return q16_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      1:       return q16_t'($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000;
      2:       return ($urandom_range(0, 1) == 1) ? Q_MAX : Q_MIN;
      default: return q16_t'($urandom);
    endcase
  endfunction

  task automatic random_phase();
    q16_t                        c [pbrf_pkg::MAX_TERMS];
    logic [pbrf_pkg::WORD_W-1:0] terms;
    logic [pbrf_pkg::WORD_W-1:0] tol_data;
    int                          k;
    int                          style;
    int                          pick;
    q16_t                        a;
    q16_t                        b;
    style = $urandom_range(0, 9);
    for (k = 0; k < pbrf_pkg::MAX_TERMS; k++) begin
      if (style < 5) c[k] = random_coef(0);
      else if (style < 7) c[k] = random_coef(1);
      else if (style < 8) c[k] = random_coef($urandom_range(0, 3));
      else c[k] = random_coef(3);
    end
    terms = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) * 7 : $urandom_range(1, 6);
    // The upper half of the tolerance word carries random junk the block drops.
    case ($urandom_range(0, 5))
      0:       tol_data = 0;
      1:       tol_data = 1;
      2:       tol_data = 16'hFFFF;
      3:       tol_data = $urandom_range(1, 64);
      default: tol_data = $urandom_range(1, 16'hFFFF);
    endcase
    tol_data[pbrf_pkg::WORD_W-1:pbrf_pkg::TOL_W] =
        (pbrf_pkg::WORD_W - pbrf_pkg::TOL_W)'($urandom);
    apply_setup(terms, tol_data, c);
    send_burst = ($urandom_range(0, 3) == 0);
    take_burst = ($urandom_range(0, 3) == 0);
    for (k = 0; k < PHASE_ITEMS; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        a = q16_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        b = q16_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      end else if (pick < 7) begin
        a = -q16_t'($urandom_range(0, 32'h0100_0000));
        b = q16_t'($urandom_range(0, 32'h0100_0000));
      end else if (pick < 9) begin
        a = q16_t'($urandom);
        b = q16_t'($urandom);
      end else begin
        a = q16_t'($urandom);
        b = a + q16_t'($urandom_range(0, 64));
      end
      send_query(a, b);
    end
  endtask

  task automatic directed_part();
    q16_t c [pbrf_pkg::MAX_TERMS];
    int   k;
    // Reset registers: the constant zero polynomial makes the lower end a root.
    send_query(Q_MIN, Q_MAX);
    send_query(Q_MAX, Q_MIN);
    send_query(0, 0);

    // p(x) = x - 1.5
    foreach (c[k]) c[k] = '0;
    c[0] = -(3 * ONE / 2);
    c[1] = ONE;
    apply_setup(2, 1, c);
    send_query(-10 * ONE, 10 * ONE);
    send_query(10 * ONE, -10 * ONE);
    send_query(3 * ONE / 2, 5 * ONE);
    send_query(-3 * ONE, 3 * ONE / 2);
    send_query(2 * ONE, 5 * ONE);
    send_query(-5 * ONE, -2 * ONE);
    send_query(Q_MIN, Q_MAX);
    send_query(ONE, ONE + 3);

    // Term count zero acts as one, a tolerance of zero acts as one.
    c[0] = '0;
    c[1] = 7 * ONE;
    apply_setup(0, 32'h0001_0000, c);
    send_query(-ONE, ONE);
    send_query(Q_MAX, 5);

    // Term count above the limit, saturating coefficients, widest tolerance.
    for (k = 0; k < pbrf_pkg::MAX_TERMS; k++) c[k] = (k % 2 == 0) ? Q_MIN : Q_MAX;
    apply_setup(7, 16'hFFFF, c);
    send_query(Q_MIN, Q_MAX);
    send_query(-ONE, ONE);
    send_query(-2, 2);
    send_query(12345, -54321);

    // Steep line through 1.5: a bracket already narrower than the tolerance.
    foreach (c[k]) c[k] = '0;
    c[0] = -1536 * ONE;
    c[1] = 1024 * ONE;
    apply_setup(2, 16'hFFFF, c);
    send_query(3 * ONE / 2 - ONE / 4, 3 * ONE / 2 + ONE / 4);
    send_query(ONE, 2 * ONE);
  endtask

  initial begin : main_sequence
    int phase;
    in_bus.valid        = 1'b0;
    in_bus.lower_bound  = '0;
    in_bus.upper_bound  = '0;
    out_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = pbrf_pkg::REG_TERM_COUNT;
    cfg_bus.data        = '0;
    rst_n               = 1'b0;
    send_burst          = 1'b0;
    take_burst          = 1'b0;
    roots               = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_part();
    for (phase = 0; phase < RANDOM_PHASES; phase++) random_phase();

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (roots.fail_count == 0 && roots.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // The receiver waits for a result to show, then may hold ready low a while.
  initial begin : result_sink
    int           gap;
    root_report_t got;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(take_burst);
      @(negedge clk);
      out_bus.ready <= (gap == 0);
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      if (gap > 0) begin
        repeat (gap) @(negedge clk);
        out_bus.ready <= 1'b1;
        @(posedge clk);
        while (!out_bus.valid) @(posedge clk);
      end
      got.root     = out_bus.root_estimate;
      got.value    = out_bus.value_at_root;
      got.status   = pbrf_pkg::status_t'(out_bus.status);
      got.halvings = out_bus.iteration_count;
      roots.check_result(got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
